// ===== rtl/core/bcpd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap cell pixel decoder package
// Shared sizes, codes and the row decode function of the pixel decoder.
// ----------------------------------------------------------------------------
package bcpd_pkg;

  // Screen geometry in cells.
  localparam int COLUMNS = 40;
  localparam int ROWS    = 25;

  // Store sizes.
  localparam int BITMAP_AW = 13;
  localparam int CELL_AW   = 10;

  // Item operations.
  localparam logic OP_WRITE   = 1'b0;
  localparam logic OP_RESOLVE = 1'b1;

  // Write targets.
  localparam logic [1:0] RGN_BITMAP = 2'd0;
  localparam logic [1:0] RGN_UPPER  = 2'd1;
  localparam logic [1:0] RGN_LOWER  = 2'd2;
  localparam logic [1:0] RGN_COLOUR = 2'd3;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 5;
  localparam logic [CFG_IDX_W-1:0] CFG_SPLIT_ENABLED     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPLIT_ROW         = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_UPPER_MULTICOLOUR = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UPPER_BACKGROUND  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LOWER_BACKGROUND  = 3'd4;

  localparam logic [4:0] SPLIT_ROW_RESET = 5'd18;

  // Decode one bitmap byte into eight 4-bit colour indices, leftmost pixel on top.
  function automatic logic [31:0] decode_row(
    input logic [7:0] bits,
    input logic       multi,
    input logic [3:0] bg,
    input logic [3:0] hi,
    input logic [3:0] lo,
    input logic [3:0] cs
  );
    logic [31:0] word;
    logic [1:0]  pair;
    logic [3:0]  c;
    word = '0;
    for (int p = 0; p < 4; p++) begin
      pair = bits[7-2*p -: 2];
      case (pair)
        2'd0:    c = bg;
        2'd1:    c = hi;
        2'd2:    c = lo;
        default: c = cs;
      endcase
      if (multi) begin
        word[31-8*p -: 8] = {c, c};
      end
    end
    if (!multi) begin
      for (int p = 0; p < 8; p++) begin
        word[31-4*p -: 4] = bits[7-p] ? hi : lo;
      end
    end
    return word;
  endfunction

endpackage

// ===== rtl/core/bitmap_cell_pixel_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap cell pixel decoder
// Holds bitmap and cell colour memories and expands one cell into pixel rows.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass that zeroes the bitmap, both
// cell colour blocks and the colour store; in_stall stays high during that
// pass while configuration writes are taken as usual. Write and resolve
// beats are accepted only while idle. For a resolve beat the fetch state
// reads the cell bytes and the first bitmap byte, then the row state gives
// one result row per cycle when the output side does not stall, since the
// bitmap memory has a single read port and each row needs one byte. A resolve
// beat for a cell outside the screen gives no result; the block stays idle.
module bitmap_cell_pixel_decoder
  import bcpd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // Configuration port
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // Input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_operation,
  input  logic [1:0]            in_region,
  input  logic [12:0]           in_address,
  input  logic [7:0]            in_data,
  input  logic [5:0]            in_cell_column,
  input  logic [4:0]            in_cell_row,
  // Result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [2:0]            out_sub_row,
  output logic [31:0]           out_pixels,
  output logic                  out_last_row
);

  // Sequencer states.
  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_FETCH = 2'd2;
  localparam logic [1:0] ST_ROW   = 2'd3;

  // Configuration registers.
  logic       split_enabled_r;
  logic [4:0] split_row_r;
  logic       upper_multicolour_r;
  logic [3:0] upper_background_r;
  logic [3:0] lower_background_r;

  // Control state.
  logic [1:0]           state_r, state_nxt;
  logic [BITMAP_AW-1:0] clr_cnt_r;
  logic [2:0]           sub_r;
  logic                 out_valid_r;

  // Per-cell working registers, loaded when an on-screen resolve beat is accepted.
  logic [CELL_AW-1:0] cell_r;
  logic               lower_r;
  logic               multi_r;
  logic [3:0]         bg_r;

  // Output payload registers.
  logic [2:0]  out_sub_row_r;
  logic [31:0] out_pixels_r;
  logic        out_last_row_r;

  // Memories and their registered read data.
  logic [7:0] bitmap_mem [2**BITMAP_AW];
  logic [7:0] upper_mem  [2**CELL_AW];
  logic [7:0] lower_mem  [2**CELL_AW];
  logic [3:0] colour_mem [2**CELL_AW];
  logic [7:0] bitmap_q;
  logic [7:0] upper_q;
  logic [7:0] lower_q;
  logic [3:0] colour_q;

  logic                  in_accept;
  logic                  wr_beat;
  logic                  rs_beat;
  logic                  in_range;
  logic [CELL_AW-1:0]    cell_idx;
  logic                  lower_sel;
  logic                  clearing;
  logic [BITMAP_AW-1:0]  bmp_waddr;
  logic [CELL_AW-1:0]    cell_waddr;
  logic [7:0]            wdata;
  logic                  row_load;
  logic                  bmp_re;
  logic [2:0]            bmp_sub;
  logic [7:0]            cell_byte;
  logic [31:0]           row_pixels;

  // --------------------------------------------------------------------------
  // Configuration writes
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      split_enabled_r     <= 1'b0;
      split_row_r         <= SPLIT_ROW_RESET;
      upper_multicolour_r <= 1'b0;
      upper_background_r  <= '0;
      lower_background_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SPLIT_ENABLED:     split_enabled_r     <= cfg_data[0];
        CFG_SPLIT_ROW:         split_row_r         <= cfg_data[4:0];
        CFG_UPPER_MULTICOLOUR: upper_multicolour_r <= cfg_data[0];
        CFG_UPPER_BACKGROUND:  upper_background_r  <= cfg_data[3:0];
        CFG_LOWER_BACKGROUND:  lower_background_r  <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Input decode
  // --------------------------------------------------------------------------
  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign wr_beat   = in_accept && (in_operation == OP_WRITE);

  // The cell index is a multiply by a small constant, kept to the depth of the
  // cell stores; the bitmap address of a row is that index times eight plus
  // the row, which wraps to the cell index bits shifted up by three.
  assign cell_idx = CELL_AW'(in_cell_row) * CELL_AW'(COLUMNS)
                  + CELL_AW'(in_cell_column);
  assign in_range = (7'(in_cell_column) < 7'(COLUMNS)) && (6'(in_cell_row) < 6'(ROWS));
  assign rs_beat  = in_accept && (in_operation == OP_RESOLVE) && in_range;

  assign lower_sel = split_enabled_r && (in_cell_row >= split_row_r);

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  assign clearing = (state_r == ST_CLEAR);
  assign row_load = (state_r == ST_ROW) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (&clr_cnt_r) state_nxt = ST_IDLE;
      ST_IDLE:  if (rs_beat) state_nxt = ST_FETCH;
      ST_FETCH: state_nxt = ST_ROW;
      ST_ROW:   if (row_load && (&sub_r)) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_cnt_r <= '0;
      sub_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (clearing) begin
        clr_cnt_r <= clr_cnt_r + BITMAP_AW'(1);
      end
      if (rs_beat) begin
        sub_r <= '0;
      end else if (row_load) begin
        sub_r <= sub_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rs_beat) begin
      cell_r  <= cell_idx;
      lower_r <= lower_sel;
      multi_r <= lower_sel || upper_multicolour_r;
      bg_r    <= lower_sel ? lower_background_r : upper_background_r;
    end
  end

  // --------------------------------------------------------------------------
  // Memories: one write port shared by the clearing pass and write beats, one
  // registered read port each. Writes only happen while clearing or idle, so
  // reads of a resolve never overlap a write.
  // --------------------------------------------------------------------------
  assign bmp_waddr  = clearing ? clr_cnt_r : in_address;
  assign cell_waddr = bmp_waddr[CELL_AW-1:0];
  assign wdata      = clearing ? 8'h00 : in_data;

  // The first bitmap byte is read with the cell bytes; each later byte is read
  // as the row before it goes to the output register.
  assign bmp_re  = (state_r == ST_FETCH) || (row_load && !(&sub_r));
  assign bmp_sub = (state_r == ST_FETCH) ? 3'd0 : sub_r + 3'd1;

  always_ff @(posedge clk) begin
    if (clearing || (wr_beat && in_region == RGN_BITMAP)) begin
      bitmap_mem[bmp_waddr] <= wdata;
    end
    if (bmp_re) begin
      bitmap_q <= bitmap_mem[{cell_r, bmp_sub}];
    end
  end

  always_ff @(posedge clk) begin
    if (clearing || (wr_beat && in_region == RGN_UPPER)) begin
      upper_mem[cell_waddr] <= wdata;
    end
    if (state_r == ST_FETCH) begin
      upper_q <= upper_mem[cell_r];
    end
  end

  always_ff @(posedge clk) begin
    if (clearing || (wr_beat && in_region == RGN_LOWER)) begin
      lower_mem[cell_waddr] <= wdata;
    end
    if (state_r == ST_FETCH) begin
      lower_q <= lower_mem[cell_r];
    end
  end

  always_ff @(posedge clk) begin
    if (clearing || (wr_beat && in_region == RGN_COLOUR)) begin
      colour_mem[cell_waddr] <= wdata[3:0];
    end
    if (state_r == ST_FETCH) begin
      colour_q <= colour_mem[cell_r];
    end
  end

  // --------------------------------------------------------------------------
  // Row decode and output register
  // --------------------------------------------------------------------------
  assign cell_byte  = lower_r ? lower_q : upper_q;
  assign row_pixels = decode_row(bitmap_q, multi_r, bg_r, cell_byte[7:4], cell_byte[3:0],
                                 colour_q);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (row_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (row_load) begin
      out_sub_row_r  <= sub_r;
      out_pixels_r   <= row_pixels;
      out_last_row_r <= &sub_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_sub_row  = out_sub_row_r;
  assign out_pixels   = out_pixels_r;
  assign out_last_row = out_last_row_r;

`ifndef SYNTHESIS
  // The last row of a cell returns the sequencer to idle.
  a_last_row_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (row_load && (&sub_r)) |=> (state_r == ST_IDLE))
    else $error("sequencer did not return to idle after the last row");

  // Rows of a cell leave in order, one step at a time.
  a_rows_in_order: assert property (@(posedge clk) disable iff (!rst_n)
    (row_load && !(&sub_r)) |=> (sub_r == $past(sub_r) + 3'd1))
    else $error("row counter skipped or repeated a row");

  // The last-row flag marks exactly the eighth row.
  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_last_row_r == (out_sub_row_r == 3'd7)))
    else $error("last-row flag does not match the row number");
`endif

endmodule

// ===== verif/tb_bitmap_cell_pixel_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap cell pixel decoder testbench
// Drives write and resolve beats into the decoder and keeps its own copy of the
// bitmap, cell and colour stores and of the registers. Each accepted resolve
// beat is expanded into the eight pixel rows it must produce, and every result
// beat is checked against the oldest of them. Directed beats cover the field
// extremes, address wrapping, both pixel modes and the raster split. Random
// phases then run well-formed fill-and-resolve sequences mixed with noise,
// under bursty input and a changing output stall pattern.
// ----------------------------------------------------------------------------
module tb_bitmap_cell_pixel_decoder;
  import bcpd_pkg::*;

  // The run is stopped as failed after this many cycles. The slowest correct
  // run (clearing pass, heavy output stalls, long holds) is far below it.
  localparam int LIMIT_CYCLES = 400000;
  // Cycles allowed after the last result for a beat still in flight that
  // causes no result, such as an off-screen resolve.
  localparam int SETTLE_CYCLES = 16;
  localparam int BITMAP_DEPTH  = 1 << BITMAP_AW;
  localparam int CELL_DEPTH    = 1 << CELL_AW;
  localparam int PRINT_LIMIT   = 40;
  localparam int PHASE_BEATS   = 58;
  localparam int RANDOM_PHASES = 6;

  // One result beat: a pixel row of the resolved cell.
  typedef struct packed {
    logic [2:0]  sub_row;
    logic [31:0] pixels;
    logic        last_row;
  } pixel_row_t;

  // One input beat.
  typedef struct packed {
    logic        operation;
    logic [1:0]  region;
    logic [12:0] address;
    logic [7:0]  data;
    logic [5:0]  cell_column;
    logic [4:0]  cell_row;
  } decoder_beat_t;

  // Output stall patterns of the receiver.
  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_t;

  // All inputs of the block start at known values.
  logic                  clk            = 1'b0;
  logic                  rst_n          = 1'b0;
  logic                  cfg_we         = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index      = '0;
  logic [CFG_DATA_W-1:0] cfg_data       = '0;
  logic                  in_valid       = 1'b0;
  logic                  in_operation   = 1'b0;
  logic [1:0]            in_region      = '0;
  logic [12:0]           in_address     = '0;
  logic [7:0]            in_data        = '0;
  logic [5:0]            in_cell_column = '0;
  logic [4:0]            in_cell_row    = '0;
  logic                  out_stall      = 1'b0;
  logic                  in_stall;
  logic                  out_valid;
  logic [2:0]            out_sub_row;
  logic [31:0]           out_pixels;
  logic                  out_last_row;

  bitmap_cell_pixel_decoder DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_operation   (in_operation),
    .in_region      (in_region),
    .in_address     (in_address),
    .in_data        (in_data),
    .in_cell_column (in_cell_column),
    .in_cell_row    (in_cell_row),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_sub_row    (out_sub_row),
    .out_pixels     (out_pixels),
    .out_last_row   (out_last_row)
  );

  always #5 clk = ~clk;

  // Shadow copy of the block's memories and registers.
  logic [7:0] bitmap_mem  [BITMAP_DEPTH];
  logic [7:0] upper_cells [CELL_DEPTH];
  logic [7:0] lower_cells [CELL_DEPTH];
  logic [3:0] colour_mem  [CELL_DEPTH];
  logic       split_on        = 1'b0;
  logic [4:0] split_first_row = SPLIT_ROW_RESET;
  logic       upper_multi     = 1'b0;
  logic [3:0] upper_bg        = '0;
  logic [3:0] lower_bg        = '0;

  // Pixel rows that the block still owes, oldest first.
  pixel_row_t expected_rows[$];

  int errors        = 0;
  int burst_left    = 0;
  int hold_request  = 0;
  int cycle_count   = 0;

  // --------------------------------------------------------------------------
  // Mismatch reporting. Every failure is counted; only the first few print so
  // that a badly broken block cannot flood the log.
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    errors++;
    if (errors <= PRINT_LIMIT) begin
      $display("%0t ns: %s mismatch: got %h, expected %h", $time, what, got, want);
    end
  endtask

  // --------------------------------------------------------------------------
  // Predictor. A write beat updates the shadow stores; a resolve beat for an
  // on-screen cell queues its eight pixel rows.
  // --------------------------------------------------------------------------
  task automatic clear_shadow_stores();
    for (int i = 0; i < BITMAP_DEPTH; i++) begin
      bitmap_mem[i] = '0;
    end
    for (int i = 0; i < CELL_DEPTH; i++) begin
      upper_cells[i] = '0;
      lower_cells[i] = '0;
      colour_mem[i]  = '0;
    end
  endtask

  task automatic expand_cell(input logic [5:0] col, input logic [4:0] row);
    logic        use_lower;
    logic        multi;
    int unsigned cell_idx;
    logic [7:0]  cell_byte;
    logic [7:0]  bits;
    logic [3:0]  palette [4];
    logic [3:0]  colour;
    pixel_row_t  row_exp;
    // Cells off the screen are dropped without a result.
    if (col >= COLUMNS || row >= ROWS) begin
      return;
    end
    // The split sends rows at or below the split row to the lower panel, which
    // is always multicolour.
    use_lower  = split_on && (row >= split_first_row);
    multi      = use_lower || upper_multi;
    cell_idx   = row * COLUMNS + col;
    cell_byte  = use_lower ? lower_cells[cell_idx % CELL_DEPTH]
                           : upper_cells[cell_idx % CELL_DEPTH];
    palette[0] = use_lower ? lower_bg : upper_bg;
    palette[1] = cell_byte[7:4];
    palette[2] = cell_byte[3:0];
    palette[3] = colour_mem[cell_idx % CELL_DEPTH];
    for (int s = 0; s < 8; s++) begin
      bits           = bitmap_mem[(cell_idx * 8 + s) % BITMAP_DEPTH];
      row_exp.pixels = '0;
      // Pixels are shifted in from the left edge of the cell. In multicolour
      // mode neighboring pixels share one bit pair, which doubles their width.
      for (int p = 0; p < 8; p++) begin
        if (multi) begin
          colour = palette[{bits[7 - (p / 2) * 2], bits[6 - (p / 2) * 2]}];
        end else begin
          colour = bits[7 - p] ? cell_byte[7:4] : cell_byte[3:0];
        end
        row_exp.pixels = {row_exp.pixels[27:0], colour};
      end
      row_exp.sub_row  = 3'(s);
      row_exp.last_row = (s == 7);
      expected_rows.push_back(row_exp);
    end
  endtask

  task automatic apply_beat(input decoder_beat_t beat);
    if (beat.operation == OP_WRITE) begin
      case (beat.region)
        RGN_BITMAP: bitmap_mem[beat.address]             = beat.data;
        RGN_UPPER:  upper_cells[beat.address[CELL_AW-1:0]] = beat.data;
        RGN_LOWER:  lower_cells[beat.address[CELL_AW-1:0]] = beat.data;
        default:    colour_mem[beat.address[CELL_AW-1:0]]  = beat.data[3:0];
      endcase
    end else begin
      expand_cell(beat.cell_column, beat.cell_row);
    end
  endtask

  // --------------------------------------------------------------------------
  // Beat construction. Fields that a beat ignores are filled at random.
  // --------------------------------------------------------------------------
  function automatic decoder_beat_t write_beat(input logic [1:0] region,
                                               input int unsigned address,
                                               input int unsigned data);
    decoder_beat_t beat;
    beat.operation   = OP_WRITE;
    beat.region      = region;
    beat.address     = address[12:0];
    beat.data        = data[7:0];
    beat.cell_column = 6'($urandom);
    beat.cell_row    = 5'($urandom);
    return beat;
  endfunction

  function automatic decoder_beat_t resolve_beat(input int unsigned col,
                                                 input int unsigned row);
    decoder_beat_t beat;
    beat.operation   = OP_RESOLVE;
    beat.region      = 2'($urandom);
    beat.address     = 13'($urandom);
    beat.data        = 8'($urandom);
    beat.cell_column = col[5:0];
    beat.cell_row    = row[4:0];
    return beat;
  endfunction

  function automatic decoder_beat_t random_onscreen_resolve();
    return resolve_beat($urandom_range(0, COLUMNS - 1), $urandom_range(0, ROWS - 1));
  endfunction

  // --------------------------------------------------------------------------
  // Sender. Beats go out in bursts of random length separated by random gaps;
  // a gap of zero joins two bursts into one longer stretch without idling.
  // Valid stays high from one beat to the next inside a burst.
  // --------------------------------------------------------------------------
  task automatic send_beat(input decoder_beat_t beat);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                : $urandom_range(1, 12);
    end
    in_valid       <= 1'b1;
    in_operation   <= beat.operation;
    in_region      <= beat.region;
    in_address     <= beat.address;
    in_data        <= beat.data;
    in_cell_column <= beat.cell_column;
    in_cell_row    <= beat.cell_row;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    // The beat was taken at this edge.
    apply_beat(beat);
    burst_left--;
  endtask

  // Stop sending and wait until every owed row has arrived, then give any
  // beat that causes no result time to leave the block.
  task automatic wait_idle();
    in_valid   <= 1'b0;
    burst_left = 0;
    while (expected_rows.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Configuration writes. They are only issued while the block is idle, so the
  // shadow registers change at the same edge as the real ones.
  // --------------------------------------------------------------------------
  task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
    case (index)
      CFG_SPLIT_ENABLED:     split_on        = value[0];
      CFG_SPLIT_ROW:         split_first_row = value[4:0];
      CFG_UPPER_MULTICOLOUR: upper_multi     = value[0];
      CFG_UPPER_BACKGROUND:  upper_bg        = value[3:0];
      CFG_LOWER_BACKGROUND:  lower_bg        = value[3:0];
      default: ;
    endcase
  endtask

  task automatic apply_config(input logic split_en, input logic [4:0] first_row,
                              input logic multi, input logic [3:0] up_bg,
                              input logic [3:0] low_bg);
    write_register(CFG_SPLIT_ENABLED, CFG_DATA_W'(split_en));
    write_register(CFG_SPLIT_ROW, CFG_DATA_W'(first_row));
    write_register(CFG_UPPER_MULTICOLOUR, CFG_DATA_W'(multi));
    write_register(CFG_UPPER_BACKGROUND, CFG_DATA_W'(up_bg));
    write_register(CFG_LOWER_BACKGROUND, CFG_DATA_W'(low_bg));
    cfg_we <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Receiver. The stall pattern switches at random among no stall, light and
  // heavy random stalls, and a periodic pattern. A hold request from a test
  // forces the stall high for the requested length, counted down here.
  // --------------------------------------------------------------------------
  stall_mode_t stall_mode = STALL_NONE;
  int          mode_left  = 0;
  int          hold_left  = 0;

  always @(posedge clk) begin
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (mode_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      mode_left  = $urandom_range(32, 256);
    end
    mode_left--;
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      case (stall_mode)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall <= ($urandom_range(0, 9) < 6);
        default:     out_stall <= ((cycle_count % 7) < 3);
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Result checker. A result beat is taken at an edge where out_valid is high
  // and out_stall low; it is compared field by field with the oldest owed row.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    pixel_row_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_rows.size() == 0) begin
        report_mismatch("unexpected result beat, pixels", out_pixels, '0);
      end else begin
        want = expected_rows.pop_front();
        if (out_sub_row !== want.sub_row) begin
          report_mismatch("sub_row", 32'(out_sub_row), 32'(want.sub_row));
        end
        if (out_pixels !== want.pixels) begin
          report_mismatch("pixels", out_pixels, want.pixels);
        end
        if (out_last_row !== want.last_row) begin
          report_mismatch("last_row", 32'(out_last_row), 32'(want.last_row));
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // With the stores cleared and the registers at reset, every pixel is zero.
  task automatic test_reset_defaults();
    send_beat(resolve_beat(0, 0));
    send_beat(resolve_beat(COLUMNS - 1, ROWS - 1));
    wait_idle();
  endtask

  // Fill the first and last cells with bit patterns that hit every pair code,
  // write through the address wrap of the 1024-entry stores, check that the
  // colour store keeps only the low nibble, and resolve off-screen cells.
  task automatic test_directed_writes();
    int unsigned last_cell;
    last_cell = (ROWS - 1) * COLUMNS + (COLUMNS - 1);
    send_beat(write_beat(RGN_BITMAP, 0, 8'hFF));
    send_beat(write_beat(RGN_BITMAP, 1, 8'h1B));
    send_beat(write_beat(RGN_BITMAP, 2, 8'hE4));
    send_beat(write_beat(RGN_BITMAP, 3, 8'h80));
    send_beat(write_beat(RGN_BITMAP, 7, 8'h01));
    send_beat(write_beat(RGN_UPPER, 0, 8'hC3));
    send_beat(write_beat(RGN_LOWER, 0, 8'h5A));
    send_beat(write_beat(RGN_COLOUR, 0, 8'hF7));
    send_beat(write_beat(RGN_COLOUR, CELL_DEPTH + last_cell, 8'hFE));
    send_beat(write_beat(RGN_UPPER, 7 * CELL_DEPTH + last_cell, 8'h21));
    send_beat(write_beat(RGN_LOWER, 7 * CELL_DEPTH + last_cell, 8'h96));
    send_beat(write_beat(RGN_BITMAP, last_cell * 8 + 7, 8'h6C));
    send_beat(write_beat(RGN_BITMAP, BITMAP_DEPTH - 1, 8'hFF));
    send_beat(resolve_beat(0, 0));
    send_beat(resolve_beat(COLUMNS - 1, ROWS - 1));
    // Off-screen cells: column past the edge, row past the bottom, both maxed.
    send_beat(resolve_beat(COLUMNS, 0));
    send_beat(resolve_beat(0, ROWS));
    send_beat(resolve_beat(63, 31));
    wait_idle();
  endtask

  // Walk the registers through their extremes and through a split that falls
  // between the first and the last cell row.
  task automatic test_register_extremes();
    apply_config(1'b0, 5'd18, 1'b1, 4'hF, 4'h0);
    send_beat(resolve_beat(0, 0));
    send_beat(resolve_beat(COLUMNS - 1, ROWS - 1));
    wait_idle();
    apply_config(1'b1, 5'd0, 1'b0, 4'h0, 4'hF);
    send_beat(resolve_beat(0, 0));
    send_beat(resolve_beat(COLUMNS - 1, ROWS - 1));
    wait_idle();
    apply_config(1'b1, 5'(ROWS - 1), 1'b0, 4'h5, 4'hA);
    send_beat(resolve_beat(0, 0));
    send_beat(resolve_beat(COLUMNS - 1, ROWS - 1));
    wait_idle();
    apply_config(1'b1, 5'd31, 1'b1, 4'hF, 4'hF);
    send_beat(resolve_beat(0, 0));
    send_beat(resolve_beat(COLUMNS - 1, ROWS - 1));
    wait_idle();
  endtask

  // The receiver holds off for a long stretch while resolves keep coming, so
  // the block fills and must stall its input; then the sender waits for every
  // owed row before going on.
  task automatic test_backpressure();
    hold_request = 400;
    repeat (24) send_beat(random_onscreen_resolve());
    wait_idle();
  endtask

  // Random phases, each under a fresh register setting. Most traffic is a
  // well-formed sequence: fill some bytes of one on-screen cell, then resolve
  // it. The rest is noise: fully random beats, random resolves that may fall
  // off the screen, and random writes anywhere.
  task automatic test_random_traffic();
    int          sent;
    int unsigned col;
    int unsigned row;
    int unsigned cell_idx;
    int unsigned fills;
    int unsigned pick;
    int unsigned first_row;
    decoder_beat_t beat;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case ($urandom_range(0, 3))
        0:       first_row = 0;
        1:       first_row = 31;
        default: first_row = $urandom_range(0, ROWS - 1);
      endcase
      apply_config(1'($urandom), 5'(first_row), 1'($urandom), 4'($urandom),
                   4'($urandom));
      sent = 0;
      while (sent < PHASE_BEATS) begin
        pick = $urandom_range(0, 99);
        if (pick < 65) begin
          col      = $urandom_range(0, COLUMNS - 1);
          row      = $urandom_range(0, ROWS - 1);
          cell_idx = row * COLUMNS + col;
          fills    = $urandom_range(1, 4);
          repeat (fills) begin
            case ($urandom_range(0, 3))
              0: send_beat(write_beat(RGN_BITMAP, cell_idx * 8 + $urandom_range(0, 7),
                                      $urandom));
              1: send_beat(write_beat(RGN_UPPER,
                                      cell_idx + ($urandom_range(0, 7) << CELL_AW),
                                      $urandom));
              2: send_beat(write_beat(RGN_LOWER,
                                      cell_idx + ($urandom_range(0, 7) << CELL_AW),
                                      $urandom));
              default: send_beat(write_beat(RGN_COLOUR,
                                            cell_idx + ($urandom_range(0, 7) << CELL_AW),
                                            $urandom));
            endcase
            sent++;
          end
          send_beat(resolve_beat(col, row));
          sent++;
        end else if (pick < 80) begin
          beat = decoder_beat_t'(35'({$urandom, $urandom}));
          send_beat(beat);
          if (beat.operation == OP_WRITE ||
              (beat.cell_column < COLUMNS && beat.cell_row < ROWS)) begin
            sent++;
          end
        end else if (pick < 90) begin
          beat = resolve_beat($urandom_range(0, 63), $urandom_range(0, 31));
          send_beat(beat);
          if (beat.cell_column < COLUMNS && beat.cell_row < ROWS) begin
            sent++;
          end
        end else begin
          send_beat(write_beat(2'($urandom), $urandom, $urandom));
          sent++;
        end
      end
      wait_idle();
    end
  endtask

  // --------------------------------------------------------------------------
  // Watchdog: ends the run as failed if it has not finished in time.
  // --------------------------------------------------------------------------
  initial begin : watchdog
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TEST FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence. Reset is held low at the start; the block then runs its
  // clearing pass with in_stall high, which the sender simply waits out.
  // --------------------------------------------------------------------------
  initial begin
    clear_shadow_stores();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_directed_writes();
    test_register_extremes();
    test_backpressure();
    test_random_traffic();
    wait_idle();
    if (expected_rows.size() != 0) begin
      report_mismatch("rows still owed at end", expected_rows.size(), '0);
    end
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
